// ----- rtl/smsub_pkg.sv -----
// shared types, constants and helpers of the stream marker substitute block
package smsub_pkg;

  localparam int DEF_MAX_MARKER_BYTES = 8;
  localparam int DEF_MAX_TEXT_BYTES   = 8;

  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int LEN_W      = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_BYTES       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_LENGTH      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DROP_FIRST_LINE    = 3'd4;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // control of one hold cell
  typedef struct packed {
    logic load;
    logic shift;
  } smsub_cell_ctrl_t;

  // request from the sequencer to the output stage
  typedef struct packed {
    logic              emit;
    logic              finish;
    logic [BYTE_W-1:0] data;
  } smsub_push_t;

  function automatic logic [BYTE_W-1:0] byte_of(input logic [CFG_W-1:0] word,
                                                input logic [2:0]       idx);
    byte_of = word[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

// ----- rtl/smsub_cell.sv -----
// one hold cell: stores a held byte, compares it with its marker byte, shifts left
module smsub_cell
  import smsub_pkg::*;
(
  input  logic              clk,
  input  smsub_cell_ctrl_t  ctrl,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [BYTE_W-1:0] next_byte,
  input  logic [BYTE_W-1:0] marker_byte,
  input  logic              active,
  output logic [BYTE_W-1:0] byte_o,
  output logic              ok
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.load) begin
      byte_nxt = load_byte;
    end else if (ctrl.shift) begin
      byte_nxt = next_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_o = byte_r;
  // an inactive cell never breaks the match
  assign ok     = !active || (byte_r == marker_byte);

endmodule

// ----- rtl/smsub_outq.sv -----
// output stage: one staging byte to learn the last of a run, then the output register
module smsub_outq
  import smsub_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  smsub_push_t       push,
  output logic              push_rdy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  logic              stage_v_r, stage_v_nxt;
  logic [BYTE_W-1:0] stage_b_r, stage_b_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_b_r, out_b_nxt;
  logic              out_last_r, out_last_nxt;

  assign push_rdy = !stage_v_r || !out_v_r || out_ready;

  always_comb begin
    stage_v_nxt  = stage_v_r;
    stage_b_nxt  = stage_b_r;
    out_v_nxt    = out_v_r;
    out_b_nxt    = out_b_r;
    out_last_nxt = out_last_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if ((push.emit || push.finish) && stage_v_r) begin
      out_v_nxt    = 1'b1;
      out_b_nxt    = stage_b_r;
      out_last_nxt = push.finish;
    end
    if (push.emit) begin
      stage_v_nxt = 1'b1;
      stage_b_nxt = push.data;
    end else if (push.finish) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    stage_b_r  <= stage_b_nxt;
    out_b_r    <= out_b_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_byte        = out_b_r;
  assign out_last_of_run = out_last_r;

endmodule

// ----- rtl/stream_marker_substitute_top.sv -----
// top level of the stream marker substitute block: config, sequencer, hold cells
// Streaming find and replace over a byte stream. Bytes enter on the in_ channel
// (valid/ready, one byte and an end-of-stream flag per transfer); every leftmost,
// non-overlapping occurrence of the marker is replaced by the replacement text and
// all other bytes leave in order on the out_ channel, the last byte caused by one
// input transfer flagged with out_last_of_run. The cfg_ port writes the marker,
// its length, the replacement, its length and the drop-first-line switch; write
// only while the block is idle.
// An input byte that leaves the held marker prefix consistent is accepted, then
// checked in one compare pass over the hold cells. Each held byte that slides out
// on a mismatch, each replacement byte and each byte flushed at end of stream takes
// one output push, with one push per cycle while the output stage is not full; a
// matched marker with a replacement or an end of stream adds a closing push. A byte
// discarded in the first line is only accepted, or at end of stream also flushes the
// held bytes. A pushed byte waits in the staging byte for the next push to move it on.
// Reset clears the match count, arms the first-line drop and loads the register
// defaults. When the receiver stalls, results wait in a staging byte and the output
// register, then the sequencer holds; input is taken only between items.
module stream_marker_substitute_top
  import smsub_pkg::*;
#(
  parameter int MAX_MARKER_BYTES = DEF_MAX_MARKER_BYTES,
  parameter int MAX_TEXT_BYTES   = DEF_MAX_TEXT_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  in_end_of_stream,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last_of_run
);

  localparam int CW = $clog2(MAX_MARKER_BYTES + 1);  // count of held bytes
  localparam int TW = $clog2(MAX_TEXT_BYTES + 2);    // replacement index

  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an input transfer
  localparam logic [1:0] ST_SCAN  = 2'd1;  // compare held bytes, slide out on mismatch
  localparam logic [1:0] ST_REPL  = 2'd2;  // push replacement text
  localparam logic [1:0] ST_FLUSH = 2'd3;  // push leftover held bytes, then close the run

  // configuration registers
  logic [CFG_W-1:0] marker_r;
  logic [LEN_W-1:0] marker_len_r;
  logic [CFG_W-1:0] repl_r;
  logic [LEN_W-1:0] repl_len_r;
  logic             drop_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r     <= '0;
      marker_len_r <= LEN_W'(1);
      repl_r       <= '0;
      repl_len_r   <= '0;
      drop_first_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MARKER_BYTES:       marker_r     <= cfg_wdata;
        REG_MARKER_LENGTH:      marker_len_r <= cfg_wdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  repl_r       <= cfg_wdata;
        REG_REPLACEMENT_LENGTH: repl_len_r   <= cfg_wdata[LEN_W-1:0];
        REG_DROP_FIRST_LINE:    drop_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective lengths: marker clamped into 1..max, replacement into 0..max
  logic [CW-1:0] mlen;
  logic [TW-1:0] tlen;

  always_comb begin
    if (marker_len_r == '0) begin
      mlen = CW'(1);
    end else if (marker_len_r > LEN_W'(MAX_MARKER_BYTES)) begin
      mlen = CW'(MAX_MARKER_BYTES);
    end else begin
      mlen = CW'(marker_len_r);
    end
    if (repl_len_r > LEN_W'(MAX_TEXT_BYTES)) begin
      tlen = TW'(MAX_TEXT_BYTES);
    end else begin
      tlen = TW'(repl_len_r);
    end
  end

  // sequencer state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;           // held bytes, matched_count between items
  logic          eos_r, eos_nxt;
  logic          pending_r, pending_nxt;
  logic [TW-1:0] idx_r, idx_nxt;

  // held count clamped below the current marker length
  logic [CW-1:0] c_eff;
  assign c_eff = (n_r >= mlen) ? mlen - CW'(1) : n_r;

  // hold cells
  smsub_cell_ctrl_t  cell_ctrl;
  logic [BYTE_W-1:0] cell_byte [MAX_MARKER_BYTES];
  logic [MAX_MARKER_BYTES-1:0] cell_ok;
  logic              match_all;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_MARKER_BYTES; gi++) begin : g_cell
      logic [BYTE_W-1:0] load_byte;
      logic [BYTE_W-1:0] next_byte;
      logic [BYTE_W-1:0] marker_byte;

      assign marker_byte = marker_r[gi*BYTE_W +: BYTE_W];
      // cells below the held count reload the marker prefix, the rest take the new byte
      assign load_byte   = (CW'(gi) < c_eff) ? marker_byte : in_byte;
      if (gi == MAX_MARKER_BYTES - 1) begin : g_tail
        assign next_byte = '0;
      end else begin : g_link
        assign next_byte = cell_byte[gi+1];
      end

      smsub_cell u_cell (
        .clk         (clk),
        .ctrl        (cell_ctrl),
        .load_byte   (load_byte),
        .next_byte   (next_byte),
        .marker_byte (marker_byte),
        .active      (CW'(gi) < n_r),
        .byte_o      (cell_byte[gi]),
        .ok          (cell_ok[gi])
      );
    end
  endgenerate

  assign match_all = &cell_ok;

  // output stage
  smsub_push_t push;
  logic        push_rdy;

  smsub_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_rdy        (push_rdy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    eos_nxt         = eos_r;
    pending_nxt     = pending_r;
    idx_nxt         = idx_r;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.shift = 1'b0;
    push.emit       = 1'b0;
    push.finish     = 1'b0;
    push.data       = cell_byte[0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cell_ctrl.load = 1'b1;
          eos_nxt        = in_end_of_stream;
          if (in_byte == NEWLINE_BYTE) begin
            pending_nxt = 1'b0;
          end
          if (pending_r && drop_first_r) begin
            // byte discarded; only an end of stream flushes the held prefix
            n_nxt = c_eff;
            if (in_end_of_stream) begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            n_nxt     = c_eff + CW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (match_all) begin
          if (n_r == mlen && tlen != '0) begin
            n_nxt     = '0;
            idx_nxt   = '0;
            state_nxt = ST_REPL;
          end else if (eos_r) begin
            if (n_r == mlen) begin
              n_nxt = '0;
            end
            state_nxt = ST_FLUSH;
          end else if (push_rdy) begin
            // marker deleted or prefix still held: close the run now
            if (n_r == mlen) begin
              n_nxt = '0;
            end
            push.finish = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (push_rdy) begin
          // oldest held byte cannot start the marker: slide it out
          push.emit       = 1'b1;
          cell_ctrl.shift = 1'b1;
          n_nxt           = n_r - CW'(1);
        end
      end

      ST_REPL: begin
        push.data = byte_of(repl_r, 3'(idx_r));
        if (push_rdy) begin
          push.emit = 1'b1;
          idx_nxt   = idx_r + TW'(1);
          if (idx_r == tlen - TW'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (push_rdy) begin
          if (n_r != '0) begin
            push.emit       = 1'b1;
            cell_ctrl.shift = 1'b1;
            n_nxt           = n_r - CW'(1);
          end else begin
            push.finish = 1'b1;
            if (eos_r) begin
              pending_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      n_r       <= '0;
      eos_r     <= 1'b0;
      pending_r <= 1'b1;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      eos_r     <= eos_nxt;
      pending_r <= pending_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ----- tb/tb_stream_marker_substitute_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the stream marker substitute block: directed table, then random streams
module tb_stream_marker_substitute_top;
  import smsub_pkg::*;

  localparam int MAX_MARKER    = DEF_MAX_MARKER_BYTES;
  localparam int MAX_TEXT      = DEF_MAX_TEXT_BYTES;
  localparam int MAX_RUN       = 16;
  // push to output register goes through the staging byte, plus a compare pass; leave plenty
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 135;
  // run limit in ns; the slowest run ends well within it
  localparam int TIMEOUT_NS    = 2_000_000;

  // one byte leaving the block
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_result_t;

  // one row of the directed table: a register write or an input byte
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic [BYTE_W-1:0]     data;
    logic                  eos;
    int                    n_typed;      // -1: take the expected bytes from the predictor
    logic [CFG_W-1:0]      typed_bytes;  // byte 0 in the low bits
  } stim_row_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr         = '0;
  logic [CFG_W-1:0]      cfg_wdata        = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte          = '0;
  logic                  in_end_of_stream = 1'b0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last_of_run;

  // substitution predictor: its own copy of the registers and the match state
  logic [CFG_W-1:0]  mk_bytes;
  logic [LEN_W-1:0]  mk_len;
  logic [CFG_W-1:0]  rp_bytes;
  logic [LEN_W-1:0]  rp_len;
  logic              drop_line;
  logic [2:0]        held_count;
  logic              first_line;

  byte_result_t expected_bytes[$];   // bytes still to come out, oldest first
  byte_result_t step_bytes[$];       // bytes caused by the item just predicted
  stim_row_t    directed_rows[$];
  int           mismatch_count = 0;

  // random idling state of both sides
  int sender_calm    = 0;
  int receiver_calm  = 0;
  int receiver_stall = 0;
  int receiver_roll;

  stream_marker_substitute_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int eff_marker_len();
    if (mk_len == 0) return 1;
    if (mk_len > MAX_MARKER) return MAX_MARKER;
    return int'(mk_len);
  endfunction

  function automatic int eff_text_len();
    if (rp_len > MAX_TEXT) return MAX_TEXT;
    return int'(rp_len);
  endfunction

  function automatic logic [BYTE_W-1:0] marker_byte(int i);
    return mk_bytes[8*i +: 8];
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] b);
    if (step_bytes.size() < MAX_RUN) step_bytes.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void reset_substitution();
    mk_bytes   = '0;
    mk_len     = 4'd1;
    rp_bytes   = '0;
    rp_len     = 4'd0;
    drop_line  = 1'b1;
    held_count = 3'd0;
    first_line = 1'b1;
  endfunction

  function automatic void apply_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_MARKER_BYTES:       mk_bytes  = val;
      REG_MARKER_LENGTH:      mk_len    = val[LEN_W-1:0];
      REG_REPLACEMENT_BYTES:  rp_bytes  = val;
      REG_REPLACEMENT_LENGTH: rp_len    = val[LEN_W-1:0];
      REG_DROP_FIRST_LINE:    drop_line = val[0];
      default: ;
    endcase
  endfunction

  // works out the bytes one input byte causes and advances the match state
  function automatic void predict_substitution(logic [BYTE_W-1:0] b, logic eos);
    logic [BYTE_W-1:0] hold [MAX_MARKER];
    byte_result_t      tail;
    int                mlen, c, n, s, k, i;
    bit                ok;
    step_bytes.delete();
    mlen = eff_marker_len();
    c    = int'(held_count);
    // held bytes are read as a prefix of the current marker
    if (c >= mlen) c = mlen - 1;
    if (first_line && drop_line) begin
      if (b == NEWLINE_BYTE) first_line = 1'b0;
    end else begin
      if (b == NEWLINE_BYTE) first_line = 1'b0;
      for (i = 0; i < c; i++) hold[i] = marker_byte(i);
      hold[c] = b;
      n = c + 1;
      // smallest slide that leaves a marker prefix; sliding all out always does
      s = n;
      for (k = n - 1; k >= 0; k--) begin
        ok = 1'b1;
        for (i = k; i < n; i++) if (hold[i] != marker_byte(i - k)) ok = 1'b0;
        if (ok) s = k;
      end
      for (i = 0; i < s; i++) push_byte(hold[i]);
      c = n - s;
      if (c >= mlen) begin
        for (i = 0; i < eff_text_len(); i++) push_byte(rp_bytes[8*i +: 8]);
        c = 0;
      end
    end
    if (eos) begin
      for (i = 0; i < c; i++) push_byte(marker_byte(i));
      c          = 0;
      first_line = 1'b1;
    end
    held_count = c[2:0];
    if (step_bytes.size() > 0) begin
      tail      = step_bytes.pop_back();
      tail.last = 1'b1;
      step_bytes.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- sender side

  // mostly back to back or short gaps, a few long ones, now and then a calm stretch
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_calm > 0) begin
      sender_calm--;
      return 0;
    end
    if (roll < 3) begin
      sender_calm = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one register write, block idle; called at a rising edge
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_cfg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer; expected bytes are typed in or come from the predictor
  task automatic send_item(logic [BYTE_W-1:0] b, logic eos, int n_typed,
                           logic [CFG_W-1:0] typed);
    int gap;
    int i;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays high into the next item when there is no gap
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_substitution(b, eos);
    if (n_typed < 0) begin
      foreach (step_bytes[j]) expected_bytes.push_back(step_bytes[j]);
    end else begin
      for (i = 0; i < n_typed; i++)
        expected_bytes.push_back('{data: typed[8*i +: 8], last: (i == n_typed - 1)});
    end
  endtask

  // sender pauses until every expected byte is out, then lets the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    directed_rows.push_back('{is_cfg: 1'b1, reg_idx: idx, reg_val: val, data: '0,
                              eos: 1'b0, n_typed: 0, typed_bytes: '0});
  endtask

  task automatic add_item(logic [BYTE_W-1:0] b, logic eos, int n_typed,
                          logic [CFG_W-1:0] typed);
    directed_rows.push_back('{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, data: b,
                              eos: eos, n_typed: n_typed, typed_bytes: typed});
  endtask

  // ---------------------------------------------------------------- receiver side

  // checks every result transfer and picks the next ready value
  always @(posedge clk) begin
    byte_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("result transfer with nothing expected: out_byte %h out_last_of_run %b",
               out_byte, out_last_of_run);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %h actual %h", want.data, out_byte);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run expected %b actual %b", want.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
    // short stalls often, long ones rarely, and stretches of steady ready
    receiver_roll = $urandom_range(0, 99);
    if (receiver_stall > 0) begin
      receiver_stall--;
      out_ready <= 1'b0;
    end else if (receiver_calm > 0) begin
      receiver_calm--;
      out_ready <= 1'b1;
    end else if (receiver_roll < 3) begin
      receiver_calm = $urandom_range(30, 80);
      out_ready <= 1'b1;
    end else if (receiver_roll < 20) begin
      receiver_stall = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else if (receiver_roll < 24) begin
      receiver_stall = $urandom_range(8, 30);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- run limit

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    stim_row_t         row;
    logic [BYTE_W-1:0] text[$];
    logic [CFG_W-1:0]  word;
    logic [BYTE_W-1:0] alpha0, alpha1;
    int                random_items;
    int                roll, mlen, plen, target, i;
    bit                end_with_eos;
    logic              eos;

    reset_substitution();
    random_items = 0;

    // reset held from the start, released once
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: one-byte marker 00, empty replacement, first line dropped
    add_item("A", 1'b0, 0, '0);                 // inside the first line: dropped
    add_item(NEWLINE_BYTE, 1'b0, 0, '0);        // newline ends the first line, dropped too
    add_item(8'h00, 1'b0, 0, '0);               // marker hit, empty replacement deletes it
    add_item(8'hFF, 1'b0, 1, 64'hFF);           // plain byte passes
    // three-byte marker, full-length replacement, no first-line drop
    add_cfg(REG_MARKER_BYTES, 64'h636261);
    add_cfg(REG_MARKER_LENGTH, 64'd3);
    add_cfg(REG_REPLACEMENT_BYTES, 64'hFFEEDDCCBBAA9988);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd8);
    add_cfg(REG_DROP_FIRST_LINE, 64'd0);
    add_item("a", 1'b0, -1, '0);
    add_item("b", 1'b0, -1, '0);
    add_item("c", 1'b0, 8, 64'hFFEEDDCCBBAA9988);
    add_item("a", 1'b0, -1, '0);
    add_item("b", 1'b0, -1, '0);
    add_item("a", 1'b0, -1, '0);                // mismatch: held bytes slide out
    add_item("x", 1'b1, -1, '0);                // mismatch slides the partial match out, end of stream closes the run
    // longest marker of all ones, deleting, first line dropped again
    add_cfg(REG_MARKER_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_MARKER_LENGTH, 64'd8);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
    add_cfg(REG_DROP_FIRST_LINE, 64'd1);
    add_item(NEWLINE_BYTE, 1'b0, 0, '0);
    for (i = 0; i < 7; i++) add_item(8'hFF, 1'b0, -1, '0);
    add_item(8'hFE, 1'b1, -1, '0);              // seven held bytes plus this one come out
    // out-of-range lengths: marker length 0 acts as 1, replacement 15 acts as 8
    add_cfg(REG_MARKER_BYTES, 64'h41);
    add_cfg(REG_MARKER_LENGTH, 64'd0);
    add_cfg(REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd15);
    add_cfg(REG_DROP_FIRST_LINE, 64'd0);
    add_item("A", 1'b0, 8, 64'h0123456789ABCDEF);
    add_item("B", 1'b1, 1, 64'h42);
    // marker shortened while two bytes are held
    add_cfg(REG_MARKER_BYTES, 64'h636261);
    add_cfg(REG_MARKER_LENGTH, 64'd3);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd1);
    add_item("a", 1'b0, -1, '0);
    add_item("b", 1'b0, -1, '0);
    add_cfg(REG_MARKER_LENGTH, 64'd1);
    add_item("q", 1'b1, -1, '0);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) begin
        drain_block();
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.data, row.eos, row.n_typed, row.typed_bytes);
      end
    end

    // random phases: new settings, then a stream rich in marker prefixes
    while (random_items < RANDOM_ITEMS) begin
      drain_block();

      roll = $urandom_range(0, 99);
      if (roll < 8) word = '0;
      else if (roll < 15) word = '1;
      else if (roll < 60) begin
        // two-letter alphabet gives overlapping, self-similar markers
        alpha0 = 8'($urandom_range(0, 255));
        alpha1 = 8'($urandom_range(0, 255));
        for (i = 0; i < 8; i++) word[8*i +: 8] = $urandom_range(0, 1) ? alpha1 : alpha0;
      end else word = {$urandom, $urandom};
      cfg_write(REG_MARKER_BYTES, word);

      roll = $urandom_range(0, 99);
      if (roll < 10) word = 64'd0;
      else if (roll < 20) word = 64'($urandom_range(9, 15));
      else if (roll < 35) word = 64'd8;
      else word = 64'($urandom_range(1, 7));
      cfg_write(REG_MARKER_LENGTH, word);

      cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});

      roll = $urandom_range(0, 99);
      if (roll < 15) word = 64'd0;
      else if (roll < 25) word = 64'($urandom_range(9, 15));
      else if (roll < 35) word = 64'd8;
      else word = 64'($urandom_range(1, 7));
      cfg_write(REG_REPLACEMENT_LENGTH, word);

      cfg_write(REG_DROP_FIRST_LINE, ($urandom_range(0, 99) < 30) ? 64'd1 : 64'd0);

      // build the text from whole markers, prefixes, newlines and noise
      text.delete();
      mlen   = eff_marker_len();
      target = $urandom_range(6, 20);
      while (text.size() < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          for (i = 0; i < mlen; i++) text.push_back(marker_byte(i));
        end else if (roll < 55) begin
          plen = $urandom_range(1, mlen);
          for (i = 0; i < plen; i++) text.push_back(marker_byte(i));
        end else if (roll < 80) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else if (roll < 90) begin
          text.push_back(NEWLINE_BYTE);
        end else begin
          text.push_back(marker_byte($urandom_range(0, mlen - 1)));
        end
      end

      // most streams end cleanly; the rest may stop mid-match before the next settings
      end_with_eos = ($urandom_range(0, 99) < 80);
      foreach (text[k]) begin
        eos = ((k == text.size() - 1) && end_with_eos) || ($urandom_range(0, 49) == 0);
        random_items++;
        send_item(text[k], eos, -1, '0);
        if ($urandom_range(0, 39) == 0) drain_block();
      end
    end

    // all stimulus in: wait for the last bytes, then let the block settle
    drain_block();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
